// ===== rtl/core/ipcr_pkg.sv =====
// Package for the IR pulse capture and replay unit.
// Holds the field widths, register reset values and default sizes.
// No dependencies.
package ipcr_pkg;

    // Configuration register widths and reset values
    localparam int GAP_W          = 20;
    localparam int LEAD_W         = 22;
    localparam int CFG_DATA_W     = 22;
    localparam int CFG_INDEX_W    = 1;
    localparam logic [GAP_W-1:0]  GAP_RESET  = 20'd50000;
    localparam logic [LEAD_W-1:0] LEAD_RESET = 22'd1000000;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEAD_DELAY = 1'b1;

    // Result field width
    localparam int STORED_COUNT_W = 8;

    // Default buffer geometry
    localparam int MAX_INTERVALS_DEF = 128;
    localparam int INTERVAL_BITS_DEF = 20;

endpackage

// ===== rtl/core/ipcr_if.sv =====
// Channel interfaces for the IR pulse capture and replay unit:
// tick input, result output and configuration write.
// Depends on ipcr_pkg.

// Tick input channel
interface ipcr_in_if;
    logic valid;
    logic ready;
    logic edge_seen;

    modport source (output valid, output edge_seen, input ready);
    modport sink (input valid, input edge_seen, output ready);
endinterface

// Result output channel
interface ipcr_out_if;
    logic                                valid;
    logic                                ready;
    logic                                carrier_on;
    logic                                transmitting;
    logic [ipcr_pkg::STORED_COUNT_W-1:0] stored_count;

    modport source (output valid, output carrier_on, output transmitting,
                    output stored_count, input ready);
    modport sink (input valid, input carrier_on, input transmitting,
                  input stored_count, output ready);
endinterface

// Configuration write channel
interface ipcr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ipcr_pkg::CFG_INDEX_W-1:0] index;
    logic [ipcr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ir_pulse_capture_replay_unit.sv =====
// Top level of the IR pulse capture and replay unit.
// Interval buffer memory, capture timing, lead delay and replay sequencing.
// Depends on ipcr_pkg and the interfaces in ipcr_if.sv.
//
// Usage:
//   i_in carries one transaction per microsecond tick with edge_seen set when
//   the receiver line changed level. Every accepted tick yields exactly one
//   result transaction on o_out (carrier_on, transmitting, stored_count),
//   showing the state after that tick.
//   i_cfg writes gap_ticks (index 0) and lead_delay_ticks (index 1); it is
//   always ready and should only be used while no tick is in flight.
//   The result is registered in the output register in the cycle after the
//   tick is accepted. One tick is taken per cycle while o_out is not stalled;
//   the next replay entry is prefetched ahead from the registered read port
//   of the interval memory.
//   A stalled o_out holds its result; i_in.ready then drops until the
//   result is taken, so no result is lost.
//   Reset: capture mode, empty buffer, registers at their defaults. The
//   buffer contents are not cleared; only entries below the count are read.
module ir_pulse_capture_replay_unit #(
    parameter int MAX_INTERVALS = ipcr_pkg::MAX_INTERVALS_DEF,
    parameter int INTERVAL_BITS = ipcr_pkg::INTERVAL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipcr_in_if.sink     i_in,
    ipcr_out_if.source  o_out,
    ipcr_cfg_if.sink    i_cfg
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int PW = (ipcr_pkg::LEAD_W > INTERVAL_BITS) ? ipcr_pkg::LEAD_W
                                                            : INTERVAL_BITS;

    // Mode codes
    localparam logic [1:0] MODE_CAPTURE = 2'd0;
    localparam logic [1:0] MODE_LEAD    = 2'd1;
    localparam logic [1:0] MODE_REPLAY  = 2'd2;

    localparam logic [INTERVAL_BITS-1:0] IVL_MAX = '1;
    localparam logic [CW-1:0]            COUNT_MAX = CW'(MAX_INTERVALS);

    // Configuration registers
    logic [ipcr_pkg::GAP_W-1:0]  r_gap_ticks;
    logic [ipcr_pkg::LEAD_W-1:0] r_lead_ticks;

    // Control state
    logic [1:0]               r_mode, n_mode;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic [INTERVAL_BITS-1:0] r_since, n_since;
    logic                     r_started, n_started;
    logic                     r_armed, n_armed;
    logic [PW-1:0]            r_pc, n_pc;

    // Interval memory
    logic [INTERVAL_BITS-1:0] r_mem [MAX_INTERVALS];
    logic [INTERVAL_BITS-1:0] r_rd;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic [AW-1:0]            wr_addr;
    logic [INTERVAL_BITS-1:0] wr_data;

    // Output register
    logic                                r_out_valid;
    logic                                r_carrier;
    logic                                r_xmit;
    logic [ipcr_pkg::STORED_COUNT_W-1:0] r_stored;

    logic                     in_ready;
    logic                     accept;
    logic                     fires;
    logic [PW-1:0]            pc_dec;
    logic [CW-1:0]            idx_inc;
    logic [INTERVAL_BITS-1:0] since_inc;
    logic [CW-1:0]            n_idx_inc;

    // Pipeline register handshake
    assign in_ready    = !r_out_valid || o_out.ready;
    assign i_in.ready  = in_ready;
    assign accept      = i_in.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.carrier_on   = r_carrier;
    assign o_out.transmitting = r_xmit;
    assign o_out.stored_count = r_stored;

    // Countdown helpers
    assign fires     = (r_pc <= PW'(1));
    assign pc_dec    = r_pc - PW'(1);
    assign idx_inc   = r_idx + CW'(1);
    assign since_inc = (r_started && (r_since != IVL_MAX)) ? r_since + INTERVAL_BITS'(1)
                                                          : r_since;

    // Tick update
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_idx     = r_idx;
        n_since   = r_since;
        n_started = r_started;
        n_armed   = r_armed;
        n_pc      = r_pc;
        mem_we    = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = since_inc;
        if (accept) begin
            case (r_mode)
                MODE_LEAD: begin
                    if (fires) begin
                        n_mode = MODE_REPLAY;
                        n_idx  = '0;
                        n_pc   = PW'(r_rd);
                    end else begin
                        n_pc = pc_dec;
                    end
                end
                MODE_REPLAY: begin
                    if (fires) begin
                        if (idx_inc < r_count) begin
                            n_idx = idx_inc;
                            n_pc  = PW'(r_rd);
                        end else begin
                            n_mode  = MODE_CAPTURE;
                            n_idx   = '0;
                            n_count = '0;
                            n_pc    = '0;
                        end
                    end else begin
                        n_pc = pc_dec;
                    end
                end
                default: begin
                    n_mode  = MODE_CAPTURE;
                    n_since = since_inc;
                    if (r_armed && fires) begin
                        // Gap expired: end of message, edge ignored
                        n_armed   = 1'b0;
                        n_started = 1'b0;
                        n_since   = '0;
                        n_pc      = '0;
                        if (r_count != '0) begin
                            n_mode = MODE_LEAD;
                            n_pc   = PW'(r_lead_ticks);
                        end
                    end else begin
                        if (r_armed) begin
                            n_pc = pc_dec;
                        end
                        if (i_in.edge_seen) begin
                            if (!r_started) begin
                                n_started = 1'b1;
                                n_since   = '0;
                            end else begin
                                if (r_count < COUNT_MAX) begin
                                    mem_we  = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                                n_since = '0;
                                n_armed = 1'b1;
                                n_pc    = PW'(r_gap_ticks);
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Prefetch address: entry 0 ahead of replay, else the entry after the current one
    assign n_idx_inc = n_idx + CW'(1);
    assign rd_addr   = (n_mode == MODE_REPLAY) ? n_idx_inc[AW-1:0] : '0;

    // Interval memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CAPTURE;
            r_count   <= '0;
            r_idx     <= '0;
            r_since   <= '0;
            r_started <= 1'b0;
            r_armed   <= 1'b0;
            r_pc      <= '0;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_since   <= n_since;
            r_started <= n_started;
            r_armed   <= n_armed;
            r_pc      <= n_pc;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks  <= ipcr_pkg::GAP_RESET;
            r_lead_ticks <= ipcr_pkg::LEAD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ipcr_pkg::CFG_GAP_TICKS: r_gap_ticks <= i_cfg.data[ipcr_pkg::GAP_W-1:0];
                ipcr_pkg::CFG_LEAD_DELAY: r_lead_ticks <= i_cfg.data[ipcr_pkg::LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, state after the accepted tick
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_carrier <= (n_mode == MODE_REPLAY) && !n_idx[0];
            r_xmit    <= (n_mode == MODE_LEAD) || (n_mode == MODE_REPLAY);
            r_stored  <= ipcr_pkg::STORED_COUNT_W'(n_count);
        end
    end

endmodule

// ===== test/ipcr_tick_checker.sv =====
// Checker for the IR pulse capture and replay unit: watches the tick, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on ipcr_pkg and the channel interfaces in ipcr_if.sv.
module ipcr_tick_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ipcr_in_if   i_tick,
    ipcr_out_if  i_result,
    ipcr_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_IVL = ipcr_pkg::MAX_INTERVALS_DEF;
    localparam int IVL_W   = ipcr_pkg::INTERVAL_BITS_DEF;
    localparam logic [IVL_W-1:0] IVL_SAT = '1;

    // Sequencer mode codes
    localparam logic [1:0] SEQ_CAPTURE = 2'd0;
    localparam logic [1:0] SEQ_LEAD    = 2'd1;
    localparam logic [1:0] SEQ_REPLAY  = 2'd2;

    typedef struct packed {
        logic                                carrier_on;
        logic                                transmitting;
        logic [ipcr_pkg::STORED_COUNT_W-1:0] stored_count;
    } t_tx_status;

    // Register copies
    logic [ipcr_pkg::GAP_W-1:0]  gap_cfg;
    logic [ipcr_pkg::LEAD_W-1:0] lead_cfg;

    // Shadow of the block state
    logic [IVL_W-1:0]            ivl_store [MAX_IVL];
    logic [7:0]                  ivl_count;
    logic [IVL_W-1:0]            since_edge;
    logic                        timing_on;
    logic                        gap_armed;
    logic [1:0]                  seq_mode;
    logic [ipcr_pkg::LEAD_W-1:0] countdown;
    logic [7:0]                  replay_idx;

    t_tx_status expected_status [$];
    int         fail_total = 0;

    // One tick of whichever countdown is running; 1 when it fires
    function automatic logic countdown_fires();
        if (countdown > ipcr_pkg::LEAD_W'(1)) begin
            countdown = countdown - 1'b1;
            return 1'b0;
        end
        countdown = '0;
        return 1'b1;
    endfunction

    // Capture: time edges, store intervals, end the message on silence
    function automatic void capture_tick(input logic rx_edge);
        if (timing_on && since_edge != IVL_SAT)
            since_edge = since_edge + 1'b1;
        if (gap_armed) begin
            if (countdown_fires()) begin
                gap_armed  = 1'b0;
                timing_on  = 1'b0;
                since_edge = '0;
                if (ivl_count != '0) begin
                    seq_mode  = SEQ_LEAD;
                    countdown = lead_cfg;
                end
                return;
            end
        end
        if (!rx_edge)
            return;
        if (!timing_on) begin
            timing_on  = 1'b1;
            since_edge = '0;
            return;
        end
        if (int'(ivl_count) < MAX_IVL) begin
            ivl_store[ivl_count] = since_edge;
            ivl_count = ivl_count + 1'b1;
        end
        since_edge = '0;
        gap_armed  = 1'b1;
        countdown  = ipcr_pkg::LEAD_W'(gap_cfg);
    endfunction

    // Advance one tick and return the status seen after it
    function automatic t_tx_status advance_replay_tick(input logic rx_edge);
        t_tx_status st;
        case (seq_mode)
            SEQ_LEAD: begin
                if (countdown_fires()) begin
                    seq_mode   = SEQ_REPLAY;
                    replay_idx = '0;
                    countdown  = ipcr_pkg::LEAD_W'(ivl_store[0]);
                end
            end
            SEQ_REPLAY: begin
                if (countdown_fires()) begin
                    replay_idx = replay_idx + 1'b1;
                    if (replay_idx < ivl_count) begin
                        countdown = ipcr_pkg::LEAD_W'(ivl_store[replay_idx]);
                    end else begin
                        seq_mode   = SEQ_CAPTURE;
                        replay_idx = '0;
                        ivl_count  = '0;
                        countdown  = '0;
                    end
                end
            end
            default: begin
                seq_mode = SEQ_CAPTURE;
                capture_tick(rx_edge);
            end
        endcase
        st.carrier_on   = (seq_mode == SEQ_REPLAY) && !replay_idx[0];
        st.transmitting = (seq_mode == SEQ_LEAD) || (seq_mode == SEQ_REPLAY);
        st.stored_count = ivl_count;
        return st;
    endfunction

    // Monitor all three channels on each edge
    always @(posedge i_clk) begin
        t_tx_status seen;
        t_tx_status want;
        if (!i_rst_n) begin
            gap_cfg    = ipcr_pkg::GAP_RESET;
            lead_cfg   = ipcr_pkg::LEAD_RESET;
            ivl_count  = '0;
            since_edge = '0;
            timing_on  = 1'b0;
            gap_armed  = 1'b0;
            seq_mode   = SEQ_CAPTURE;
            countdown  = '0;
            replay_idx = '0;
            expected_status.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == ipcr_pkg::CFG_GAP_TICKS)
                    gap_cfg = i_cfg.data[ipcr_pkg::GAP_W-1:0];
                else if (i_cfg.index == ipcr_pkg::CFG_LEAD_DELAY)
                    lead_cfg = i_cfg.data[ipcr_pkg::LEAD_W-1:0];
            end
            if (i_tick.valid && i_tick.ready)
                expected_status.push_back(advance_replay_tick(i_tick.edge_seen));
            if (i_result.valid && i_result.ready) begin
                seen.carrier_on   = i_result.carrier_on;
                seen.transmitting = i_result.transmitting;
                seen.stored_count = i_result.stored_count;
                if (expected_status.size() == 0) begin
                    $error("result transaction with no tick outstanding: %0d/%0d/%0d",
                           seen.carrier_on, seen.transmitting, seen.stored_count);
                    fail_total++;
                end else begin
                    want = expected_status.pop_front();
                    if (seen.carrier_on !== want.carrier_on) begin
                        $error("carrier_on: expected %0d, actual %0d",
                               want.carrier_on, seen.carrier_on);
                        fail_total++;
                    end
                    if (seen.transmitting !== want.transmitting) begin
                        $error("transmitting: expected %0d, actual %0d",
                               want.transmitting, seen.transmitting);
                        fail_total++;
                    end
                    if (seen.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, actual %0d",
                               want.stored_count, seen.stored_count);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    <= expected_status.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== test/tb_ir_pulse_capture_replay_unit.sv =====
// Testbench top for the IR pulse capture and replay unit: clock, reset, tick and
// register stimulus, random output stalls, watchdog and verdict.
// Depends on ipcr_pkg, ipcr_if.sv, the unit itself and ipcr_tick_checker.
module tb_ir_pulse_capture_replay_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_TARGET    = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_results;
    int   quiet_cycles = 0;
    bit   no_idle = 1'b0;
    int   sent_ticks = 0;
    int   cur_gap;
    int   cur_lead;
    int   tail_edge_pct = 0;

    ipcr_in_if  in_ch ();
    ipcr_out_if out_ch ();
    ipcr_cfg_if cfg_ch ();

    ir_pulse_capture_replay_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ipcr_tick_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (in_ch),
        .i_result     (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure
    initial begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                stall = no_idle ? 0 : pick_idle();
                out_ch.ready <= (stall == 0);
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One tick transaction; valid stays high unless a gap follows
    task automatic send_tick(input logic rx_edge);
        int idle;
        idle = no_idle ? 0 : pick_idle();
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.edge_seen <= rx_edge;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_ticks++;
    endtask

    // Hold off ticks until every result is back, then let the pipe settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both timing registers back to back
    task automatic set_timing(input int gap, input int lead);
        cur_gap  = gap;
        cur_lead = lead;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= ipcr_pkg::CFG_GAP_TICKS;
        cfg_ch.data  <= ipcr_pkg::CFG_DATA_W'(gap);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.index <= ipcr_pkg::CFG_LEAD_DELAY;
        cfg_ch.data  <= ipcr_pkg::CFG_DATA_W'(lead);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_quiet(input int n, input int edge_pct);
        repeat (n) send_tick($urandom_range(0, 99) < edge_pct);
    endtask

    // A burst of edges spaced 1..max_ivl ticks apart, then enough quiet ticks
    // for the gap to expire and the replay to finish
    task automatic send_message(input int n_edges, input int max_ivl);
        int d;
        send_tick(1'b1);
        for (int i = 1; i < n_edges; i++) begin
            d = $urandom_range(1, max_ivl);
            repeat (d - 1) send_tick(1'b0);
            send_tick(1'b1);
        end
        send_quiet(cur_gap + cur_lead + n_edges * max_ivl + 4, tail_edge_pct);
    endtask

    initial begin
        int r;
        int gap;
        int lead;
        int n;
        int max_ivl;
        in_ch.valid     = 1'b0;
        in_ch.edge_seen = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ipcr_pkg::CFG_GAP_TICKS;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        cur_gap         = int'(ipcr_pkg::GAP_RESET);
        cur_lead        = int'(ipcr_pkg::LEAD_RESET);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: a lone edge only starts timing
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_results();

        // Largest gap and lead; no further edge, so nothing is armed
        set_timing((1 << ipcr_pkg::GAP_W) - 1, (1 << ipcr_pkg::LEAD_W) - 1);
        send_quiet(3, 0);
        drain_results();

        // Shortest gap, zero lead: one interval, edge on the expiry tick is
        // dropped, edges during lead and replay are ignored
        set_timing(1, 0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_quiet(8, 100);
        send_quiet(6, 0);
        drain_results();

        // Overfilled buffer: extra edges still restart the gap timer
        set_timing(10, 3);
        send_message(131, 2);
        drain_results();

        // Random phases with fresh timing each time
        while (sent_ticks < TICK_TARGET) begin
            r = $urandom_range(0, 9);
            gap = (r == 0) ? 1 : (r == 1) ? $urandom_range(100, 300) : $urandom_range(2, 24);
            r = $urandom_range(0, 19);
            lead = (r < 3) ? 0 : (r < 5) ? 1 : $urandom_range(0, 30);
            set_timing(gap, lead);
            no_idle       = ($urandom_range(0, 3) == 0);
            tail_edge_pct = ($urandom_range(0, 2) == 0) ? 10 : 0;
            max_ivl       = (gap > 9) ? 8 : ((gap > 1) ? gap - 1 : 1);
            repeat ($urandom_range(1, 4)) begin
                if (sent_ticks >= TICK_TARGET)
                    break;
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    n = (gap == 1) ? $urandom_range(1, 2) : $urandom_range(1, 12);
                    send_message(n, max_ivl);
                end else if (r == 14 && gap >= 3) begin
                    send_message($urandom_range(129, 134), 2);
                end else if (r < 17) begin
                    // broken spacing: some intervals reach the gap itself
                    send_message($urandom_range(2, 6), gap);
                end else begin
                    n = $urandom_range(5, 40);
                    send_quiet(n, 50);
                end
            end
            drain_results();
        end
        no_idle = 1'b0;

        drain_results();
        if (fail_count == 0 && pending_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== ir_pulse_capture_replay_unit.f =====
rtl/core/ipcr_pkg.sv
rtl/core/ipcr_if.sv
rtl/core/ir_pulse_capture_replay_unit.sv
test/ipcr_tick_checker.sv
test/tb_ir_pulse_capture_replay_unit.sv
